// File: sv/swmf_pkg.sv
package swmf_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int AGE_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MID         = WINDOW / 2;

    localparam logic [AGE_BITS-1:0] OLDEST_AGE = AGE_BITS'(WINDOW - 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [AGE_BITS-1:0]           age_t;

    // What a cell shows its neighbours
    typedef struct packed {
        sample_t value;
        age_t    age;
        logic    gt;    // stored value above the incoming sample
    } cell_link_t;

    // Shared command from the top level to every cell
    typedef struct packed {
        logic    load;
        logic    preload;
        sample_t x;
    } cell_cmd_t;

endpackage

// File: sv/sliding_window_median_filter.sv
// Running median over the last WINDOW signed samples. The window is kept
// sorted in a row of cells, each holding one sample and its age; a push
// drops the oldest sample and inserts the new one in the same cycle, and
// the median is the cell at position WINDOW/2 (upper middle for an even
// window). A preload fills every cell with the given value. One item is
// taken per cycle and its result appears in the output register in the
// next cycle; that single register sets the rate, as a new transfer is
// taken only while it is empty or its result leaves in the same cycle.
// The window holds zeros after reset.
module sliding_window_median_filter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic signed [swmf_pkg::SAMPLE_BITS-1:0] sample,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [swmf_pkg::SAMPLE_BITS-1:0] median
);

    localparam int W = swmf_pkg::WINDOW;

    swmf_pkg::cell_cmd_t  cmd;
    swmf_pkg::cell_link_t link [W];
    swmf_pkg::sample_t    value_next [W];
    logic [W:0]           del;
    logic [W-1:0]         oldest;
    logic                 sorted_ok;
    logic                 in_fire;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    swmf_pkg::sample_t    median_reg;

    swmf_pkg::cell_link_t left_bound;
    swmf_pkg::cell_link_t right_bound;

    assign left_bound  = '{value: '0, age: '0, gt: 1'b0};
    assign right_bound = '{value: '0, age: '0, gt: 1'b1};

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign cmd.load    = in_fire;
    assign cmd.preload = action;
    assign cmd.x       = sample;

    assign del[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < W; i++)
        begin : g_cell
            swmf_pkg::cell_link_t lft;
            swmf_pkg::cell_link_t rgt;
            if (i == 0)
            begin : g_lb
                assign lft = left_bound;
            end
            else
            begin : g_ln
                assign lft = link[i-1];
            end
            if (i == W - 1)
            begin : g_rb
                assign rgt = right_bound;
            end
            else
            begin : g_rn
                assign rgt = link[i+1];
            end

            swmf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .init_age   (swmf_pkg::AGE_BITS'(i)),
                .left       (lft),
                .right      (rgt),
                .del_in     (del[i]),
                .del_out    (del[i+1]),
                .link       (link[i]),
                .value_next (value_next[i])
            );

            assign oldest[i] = (link[i].age == swmf_pkg::OLDEST_AGE);
        end
    endgenerate

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int k = 0; k < W - 1; k++)
        begin
            if (link[k].value > link[k+1].value)
                sorted_ok = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            median_reg <= value_next[swmf_pkg::MID];
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    // exactly one cell holds the oldest sample
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(oldest))
        else $error("oldest tag not unique");

    // the row stays in ascending order
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("cell row out of order");

    // every transfer in yields a result on the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("result missing after transfer");

    // the reported median matches the middle cell after a transfer
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (median == link[swmf_pkg::MID].value))
        else $error("median does not match middle cell");

endmodule

// File: sv/swmf_cell.sv
module swmf_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swmf_pkg::cell_cmd_t    cmd,
    input  swmf_pkg::age_t         init_age,
    input  swmf_pkg::cell_link_t   left,
    input  swmf_pkg::cell_link_t   right,
    input  logic                   del_in,
    output logic                   del_out,
    output swmf_pkg::cell_link_t   link,
    output swmf_pkg::sample_t      value_next
);

    swmf_pkg::sample_t value_reg;
    swmf_pkg::age_t    age_reg;
    swmf_pkg::age_t    age_next;
    logic              removed;
    logic              gt;

    assign removed = (age_reg == swmf_pkg::OLDEST_AGE);
    assign gt      = (value_reg > cmd.x);
    assign del_out = del_in | removed;

    assign link.value = value_reg;
    assign link.age   = age_reg;
    assign link.gt    = gt;

    // On a push, drop the oldest entry and insert the new one at once:
    // cells left of the hole shift right, cells right of it shift left.
    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg + swmf_pkg::AGE_BITS'(1);
        priority if (cmd.preload)
        begin
            value_next = cmd.x;
            age_next   = init_age;
        end
        else if (removed)
        begin
            priority if (left.gt)
            begin
                value_next = left.value;
                age_next   = left.age + swmf_pkg::AGE_BITS'(1);
            end
            else if (!right.gt)
            begin
                value_next = right.value;
                age_next   = right.age + swmf_pkg::AGE_BITS'(1);
            end
            else
            begin
                value_next = cmd.x;
                age_next   = '0;
            end
        end
        else if (!del_in)
        begin
            if (gt)
            begin
                if (left.gt)
                begin
                    value_next = left.value;
                    age_next   = left.age + swmf_pkg::AGE_BITS'(1);
                end
                else
                begin
                    value_next = cmd.x;
                    age_next   = '0;
                end
            end
        end
        else
        begin
            priority if (!right.gt)
            begin
                value_next = right.value;
                age_next   = right.age + swmf_pkg::AGE_BITS'(1);
            end
            else if (!gt)
            begin
                value_next = cmd.x;
                age_next   = '0;
            end
            else
            begin
                value_next = value_reg;
                age_next   = age_reg + swmf_pkg::AGE_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg   <= init_age;
        end
        else if (cmd.load)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

// File: tb/sv/swmf_median_check.sv
`timescale 1ns / 1ps
module swmf_median_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 action,
    input  swmf_pkg::sample_t    sample,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  swmf_pkg::sample_t    median,
    output int                   pending,
    output int                   mismatches
);

    swmf_pkg::sample_t ring [swmf_pkg::WINDOW];
    int unsigned       head;
    swmf_pkg::sample_t medians_due [$];
    swmf_pkg::sample_t want;
    int                errors = 0;

    assign mismatches = errors;

    // insertion sort of a copy of the window; upper middle for an even size
    function automatic swmf_pkg::sample_t window_median();
        swmf_pkg::sample_t sorted [swmf_pkg::WINDOW];
        swmf_pkg::sample_t key;
        int                i;
        int                j;
        for (i = 0; i < swmf_pkg::WINDOW; i++)
        begin
            sorted[i] = ring[i];
        end
        for (i = 1; i < swmf_pkg::WINDOW; i++)
        begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[swmf_pkg::MID];
    endfunction

    task automatic report(input string what, input swmf_pkg::sample_t got,
                          input swmf_pkg::sample_t exp_value);
        $display("%0t ns: median %s: got %0d, expected %0d", $realtime, what, got, exp_value);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swmf_pkg::WINDOW; i++)
            begin
                ring[i] = '0;
            end
            head = 0;
            medians_due.delete();
            pending <= 0;
        end
        else
        begin
            // result side first: a result always belongs to an earlier transfer
            if (out_valid && out_ready)
            begin
                if (medians_due.size() == 0)
                begin
                    report("transfer with nothing outstanding", median, '0);
                end
                else
                begin
                    want = medians_due.pop_front();
                    if (median !== want)
                    begin
                        report("mismatch", median, want);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (action)
                begin
                    // preload: whole window takes the value, position back to zero
                    for (int i = 0; i < swmf_pkg::WINDOW; i++)
                    begin
                        ring[i] = sample;
                    end
                    head = 0;
                    medians_due.push_back(sample);
                end
                else
                begin
                    ring[head] = sample;
                    head = (head + 1) % swmf_pkg::WINDOW;
                    medians_due.push_back(window_median());
                end
            end
            pending <= medians_due.size();
        end
    end

endmodule

// File: tb/sv/sliding_window_median_filter_tb.sv
`timescale 1ns / 1ps
module sliding_window_median_filter_tb;

    localparam logic ACT_PUSH    = 1'b0;
    localparam logic ACT_PRELOAD = 1'b1;
    localparam swmf_pkg::sample_t SAMPLE_MAX =
        {1'b0, {(swmf_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam swmf_pkg::sample_t SAMPLE_MIN =
        {1'b1, {(swmf_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam int   PHASES      = 4;
    localparam int   PHASE_ITEMS = 425;
    localparam int   LONG_HOLD   = 64;
    localparam int   TAIL_CYCLES = 8;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              action    = ACT_PUSH;
    swmf_pkg::sample_t sample    = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    swmf_pkg::sample_t median;

    int pending;
    int mismatches;
    bit sender_idle   = 1'b0;
    bit sink_idle     = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sliding_window_median_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median)
    );

    swmf_median_check median_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .median     (median),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // offer one item and hold it until the transfer
    task automatic offer(input logic act, input swmf_pkg::sample_t value);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // pending is registered and lags, so look on past the next edge before trusting it
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // duplicates and extremes matter for a median, so skew towards them
    function automatic swmf_pkg::sample_t random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3, 4: return swmf_pkg::sample_t'(int'($urandom_range(0, 16)) - 8);
            default: return swmf_pkg::sample_t'($urandom);
        endcase
    endfunction

    initial
    begin
        while (!rst_n) @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (sink_idle && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int k;
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh window: reset zeros take part in the median
        offer(ACT_PUSH, swmf_pkg::sample_t'(5));
        offer(ACT_PUSH, swmf_pkg::sample_t'(-3));
        offer(ACT_PUSH, SAMPLE_MAX);
        offer(ACT_PUSH, SAMPLE_MIN);
        // half max, half min: upper middle must come out as max
        offer(ACT_PRELOAD, SAMPLE_MAX);
        repeat (4) offer(ACT_PUSH, SAMPLE_MIN);
        offer(ACT_PUSH, SAMPLE_MIN);
        offer(ACT_PRELOAD, SAMPLE_MIN);
        offer(ACT_PUSH, '0);
        offer(ACT_PRELOAD, '0);
        for (k = 1; k <= swmf_pkg::WINDOW; k++)
        begin
            offer(ACT_PUSH, swmf_pkg::sample_t'(k));
        end
        offer(ACT_PRELOAD, swmf_pkg::sample_t'(-1));
        offer(ACT_PUSH, 24'h555555);
        offer(ACT_PUSH, 24'hAAAAAA);
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            // last phase runs flat out on both sides
            sender_idle = (phase != 1) && (phase != PHASES - 1);
            sink_idle  <= (phase != PHASES - 1);
            if (phase == 1)
            begin
                hold_requests <= hold_requests + 1;
            end
            repeat (PHASE_ITEMS)
            begin
                offer(($urandom_range(0, 15) == 0) ? ACT_PRELOAD : ACT_PUSH, random_sample());
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/swmf_pkg.sv
sv/swmf_cell.sv
sv/sliding_window_median_filter.sv
tb/sv/swmf_median_check.sv
tb/sv/sliding_window_median_filter_tb.sv
